### sv/sdas_pkg.sv
// ----------------------------------------------------------------------------
// sdas_pkg
// Shared types and timing constants for the scanline dot action sequencer.
// ----------------------------------------------------------------------------
package sdas_pkg;

  localparam int unsigned DotW = 9;

  localparam logic [DotW-1:0] DotLast        = 9'd340;
  localparam logic [DotW-1:0] DotVisEnd      = 9'd256;
  localparam logic [DotW-1:0] DotPrefetch    = 9'd320;
  localparam logic [DotW-1:0] DotPrefetchEnd = 9'd336;
  localparam logic [DotW-1:0] DotVReloadLo   = 9'd279;
  localparam logic [DotW-1:0] DotVReloadHi   = 9'd303;
  localparam logic [DotW-1:0] DotSprLo       = 9'd260;
  localparam logic [DotW-1:0] DotSprHi       = 9'd318;
  localparam logic [DotW-1:0] DotClipEnd     = 9'd8;

  typedef enum logic [1:0] {
    CFG_BG_ENABLE     = 2'd0,
    CFG_BG_CLIP       = 2'd1,
    CFG_SPRITE_ENABLE = 2'd2,
    CFG_SPRITE_CLIP   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    FETCH_NONE    = 3'd0,
    FETCH_NT      = 3'd1,
    FETCH_AT      = 3'd2,
    FETCH_PAT_LO  = 3'd3,
    FETCH_PAT_HI  = 3'd4
  } fetch_kind_t;

  typedef enum logic [1:0] {
    SPR_NONE    = 2'd0,
    SPR_FETCH0  = 2'd1,
    SPR_CLEAR   = 2'd2,
    SPR_FETCH1  = 2'd3
  } sprite_op_t;

  typedef enum logic [1:0] {
    BG_NONE       = 2'd0,
    BG_DRAW       = 2'd1,
    BG_BLANK      = 2'd2,
    BG_SHIFT_ONLY = 2'd3
  } bg_action_t;

  typedef enum logic [1:0] {
    EVAL_NONE    = 2'd0,
    EVAL_PREDRAW = 2'd1,
    EVAL_SPRITE  = 2'd2
  } eval_op_t;

  typedef struct packed {
    logic bg_enable;
    logic bg_clip;
    logic sprite_enable;
    logic sprite_clip;
  } cfg_t;

  typedef struct packed {
    logic [DotW-1:0] dot_index;
    fetch_kind_t     fetch_kind;
    logic            vert_step_horiz_reload;
    logic            vert_reload;
    sprite_op_t      sprite_fetch_op;
    logic [2:0]      sprite_slot;
    bg_action_t      bg_action;
    eval_op_t        sprite_eval_op;
    logic [5:0]      sprite_eval_index;
    logic            mask_sprite_pixel;
    logic            clear_status_flags;
    logic            end_of_line;
  } action_t;

endpackage

### sv/sdas_if.sv
// ----------------------------------------------------------------------------
// sdas_tick_if / sdas_action_if
// Valid/ready channels for dot ticks and for the per-dot action results.
// ----------------------------------------------------------------------------
interface sdas_tick_if;
  logic       valid;
  logic       ready;
  logic       line_kind;
  logic [3:0] sprites_on_line;

  modport source (output valid, line_kind, sprites_on_line, input ready);
  modport sink (input valid, line_kind, sprites_on_line, output ready);
endinterface

interface sdas_action_if;
  logic       valid;
  logic       ready;
  logic [8:0] dot_index;
  logic [2:0] fetch_kind;
  logic       vert_step_horiz_reload;
  logic       vert_reload;
  logic [1:0] sprite_fetch_op;
  logic [2:0] sprite_slot;
  logic [1:0] bg_action;
  logic [1:0] sprite_eval_op;
  logic [5:0] sprite_eval_index;
  logic       mask_sprite_pixel;
  logic       clear_status_flags;
  logic       end_of_line;

  modport source (
    output valid, dot_index, fetch_kind, vert_step_horiz_reload, vert_reload,
           sprite_fetch_op, sprite_slot, bg_action, sprite_eval_op,
           sprite_eval_index, mask_sprite_pixel, clear_status_flags, end_of_line,
    input  ready
  );
  modport sink (
    input  valid, dot_index, fetch_kind, vert_step_horiz_reload, vert_reload,
           sprite_fetch_op, sprite_slot, bg_action, sprite_eval_op,
           sprite_eval_index, mask_sprite_pixel, clear_status_flags, end_of_line,
    output ready
  );
endinterface

### sv/sdas_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdas_cfg_regs
// Rendering enable and clip control registers behind a plain write port.
// ----------------------------------------------------------------------------
module sdas_cfg_regs
  import sdas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BG_ENABLE:     cfg.bg_enable     <= cfg_data;
        CFG_BG_CLIP:       cfg.bg_clip       <= cfg_data;
        CFG_SPRITE_ENABLE: cfg.sprite_enable <= cfg_data;
        CFG_SPRITE_CLIP:   cfg.sprite_clip   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/sdas_dot_decode.sv
// ----------------------------------------------------------------------------
// sdas_dot_decode
// Decodes one dot position and line kind into the rendering action strobes.
// ----------------------------------------------------------------------------
module sdas_dot_decode
  import sdas_pkg::*;
(
  input  logic [DotW-1:0] dot,
  input  logic            line_kind,
  input  logic [3:0]      sprites_on_line,
  input  cfg_t            cfg,
  output action_t         act
);

  logic            on;
  logic            in_vis;
  logic            in_prefetch;
  logic            in_clip;
  logic            in_spr;
  logic [DotW-1:0] rel;
  logic [2:0]      slot_k;
  logic [2:0]      phase;
  logic            occupied;

  always_comb begin
    on          = cfg.bg_enable | cfg.sprite_enable;
    in_vis      = dot < DotVisEnd;
    in_prefetch = (dot >= DotPrefetch) && (dot < DotPrefetchEnd);
    in_clip     = dot < DotClipEnd;
    in_spr      = (dot >= DotSprLo) && (dot <= DotSprHi);
    rel         = dot - DotSprLo;
    slot_k      = rel[5:3];
    phase       = rel[2:0];
    occupied    = sprites_on_line > {1'b0, slot_k};

    act                        = '0;
    act.dot_index              = dot;
    act.fetch_kind             = FETCH_NONE;
    act.sprite_fetch_op        = SPR_NONE;
    act.bg_action              = BG_NONE;
    act.sprite_eval_op         = EVAL_NONE;
    act.end_of_line            = dot == DotLast;

    if (on) begin
      if (!dot[0] && (in_vis || in_prefetch)) begin
        act.fetch_kind = fetch_kind_t'({1'b0, dot[2:1]} + 3'd1);
      end
      act.vert_step_horiz_reload = dot == DotVisEnd;
      if (in_spr) begin
        if (phase == 3'd0) begin
          act.sprite_fetch_op = occupied ? SPR_FETCH0 : SPR_CLEAR;
          act.sprite_slot     = slot_k;
        end else if (phase == 3'd2 && occupied) begin
          act.sprite_fetch_op = SPR_FETCH1;
          act.sprite_slot     = slot_k;
        end
      end
      act.vert_reload = line_kind && (dot >= DotVReloadLo) && (dot <= DotVReloadHi);
    end

    if (in_prefetch) begin
      act.bg_action = BG_SHIFT_ONLY;
    end

    if (line_kind) begin
      act.clear_status_flags = dot == '0;
    end else if (in_vis) begin
      if (cfg.bg_enable) begin
        act.bg_action = (cfg.bg_clip && in_clip) ? BG_BLANK : BG_DRAW;
      end else begin
        act.bg_action = BG_BLANK;
      end
      act.mask_sprite_pixel = cfg.sprite_enable ? (cfg.sprite_clip && in_clip) : 1'b1;
      if (dot == '0) begin
        act.sprite_eval_op = EVAL_PREDRAW;
      end else if (dot[1:0] == 2'b11) begin
        act.sprite_eval_op    = EVAL_SPRITE;
        act.sprite_eval_index = dot[7:2];
      end
    end
  end

endmodule

### sv/scanline_dot_action_sequencer.sv
// ----------------------------------------------------------------------------
// scanline_dot_action_sequencer
// Per-dot rendering action sequencer for a 341-dot scanline.
// ----------------------------------------------------------------------------
// Each tick beat advances an internal dot counter (0 to 340, then wrapping)
// and yields exactly one action beat describing background fetches, scroll
// steps and reloads, sprite slot fetches, draw and shift actions, sprite
// evaluation, sprite masking and the status flag clear for that dot. A tick
// is taken whenever the input register can accept it; it passes an input
// register and a result register, and the two-stage valid/ready pipeline
// keeps full throughput of one beat per cycle while the result side takes
// its beats. Settings are read as a dot leaves the input register.
// ----------------------------------------------------------------------------
module scanline_dot_action_sequencer
  import sdas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data,
  sdas_tick_if.sink          tick,
  sdas_action_if.source      action
);

  cfg_t            cfg;
  logic [DotW-1:0] dot_position;
  logic            s1_valid;
  logic            s1_line_kind;
  logic [3:0]      s1_count;
  logic [DotW-1:0] s1_dot;
  logic            s1_ready;
  logic            s2_valid;
  logic            s2_ready;
  action_t         s2_act;
  action_t         act_next;
  logic            tick_fire;

  sdas_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s2_ready   = !s2_valid || action.ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign tick.ready = s1_ready;
  assign tick_fire  = tick.valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_position <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= tick.valid;
      end
      if (tick_fire) begin
        dot_position <= (dot_position == DotLast) ? '0 : dot_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_line_kind <= tick.line_kind;
      s1_count     <= tick.sprites_on_line;
      s1_dot       <= dot_position;
    end
  end

  sdas_dot_decode u_decode (
    .dot             (s1_dot),
    .line_kind       (s1_line_kind),
    .sprites_on_line (s1_count),
    .cfg             (cfg),
    .act             (act_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_act <= act_next;
    end
  end

  assign action.valid                  = s2_valid;
  assign action.dot_index              = s2_act.dot_index;
  assign action.fetch_kind             = s2_act.fetch_kind;
  assign action.vert_step_horiz_reload = s2_act.vert_step_horiz_reload;
  assign action.vert_reload            = s2_act.vert_reload;
  assign action.sprite_fetch_op        = s2_act.sprite_fetch_op;
  assign action.sprite_slot            = s2_act.sprite_slot;
  assign action.bg_action              = s2_act.bg_action;
  assign action.sprite_eval_op         = s2_act.sprite_eval_op;
  assign action.sprite_eval_index      = s2_act.sprite_eval_index;
  assign action.mask_sprite_pixel      = s2_act.mask_sprite_pixel;
  assign action.clear_status_flags     = s2_act.clear_status_flags;
  assign action.end_of_line            = s2_act.end_of_line;

endmodule

### bench/sdas_action_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdas_action_checker
// Watches the tick, action and settings ports of the dot action sequencer,
// works out the action beat that each accepted tick must produce from its own
// copy of the dot position and the render settings, and compares every action
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sdas_action_checker
  import sdas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  logic       cfg_data,
  sdas_tick_if       tick,
  sdas_action_if     action,
  output int         outstanding,
  output int         failures,
  output int         checked
);

  cfg_t            settings;
  logic [DotW-1:0] dot_now;
  action_t         predicted_q[$];
  int              errors = 0;
  int              beats_checked = 0;

  assign failures = errors;
  assign checked  = beats_checked;

  function automatic action_t dot_actions(input cfg_t s, input logic pre,
                                          input logic [3:0] count,
                                          input logic [DotW-1:0] dot);
    action_t    a;
    logic       rendering;
    logic [5:0] rel;
    logic [2:0] slot;
    logic       occupied;
    a = '0;
    rendering = s.bg_enable | s.sprite_enable;
    if (rendering) begin
      if (!dot[0] && (dot < DotVisEnd || (dot >= DotPrefetch && dot < DotPrefetchEnd))) begin
        a.fetch_kind = fetch_kind_t'(3'(dot[2:1]) + 3'd1);
      end
      a.vert_step_horiz_reload = (dot == DotVisEnd);
      if (dot >= DotSprLo && dot <= DotSprHi) begin
        rel = 6'(dot - DotSprLo);
        slot = rel[5:3];
        occupied = (count > {1'b0, slot});
        if (rel[2:0] == 3'd0) begin
          a.sprite_fetch_op = occupied ? SPR_FETCH0 : SPR_CLEAR;
          a.sprite_slot = slot;
        end else if (rel[2:0] == 3'd2 && occupied) begin
          a.sprite_fetch_op = SPR_FETCH1;
          a.sprite_slot = slot;
        end
      end
      a.vert_reload = pre && dot >= DotVReloadLo && dot <= DotVReloadHi;
    end
    if (dot >= DotPrefetch && dot < DotPrefetchEnd) begin
      a.bg_action = BG_SHIFT_ONLY;
    end
    if (pre) begin
      a.clear_status_flags = (dot == '0);
    end else if (dot < DotVisEnd) begin
      if (s.bg_enable) begin
        a.bg_action = (s.bg_clip && dot < DotClipEnd) ? BG_BLANK : BG_DRAW;
      end else begin
        a.bg_action = BG_BLANK;
      end
      a.mask_sprite_pixel = s.sprite_enable ? (s.sprite_clip && dot < DotClipEnd) : 1'b1;
      if (dot == '0) begin
        a.sprite_eval_op = EVAL_PREDRAW;
      end else if (dot[1:0] == 2'b11) begin
        a.sprite_eval_op = EVAL_SPRITE;
        a.sprite_eval_index = dot[7:2];
      end
    end
    a.end_of_line = (dot == DotLast);
    a.dot_index = dot;
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [8:0] got,
                               input logic [8:0] want, input logic [8:0] dot);
    if (got !== want) begin
      report_mismatch($sformatf("dot %0d %s: got %0d, expected %0d", dot, name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    action_t got;
    action_t want;
    if (rst) begin
      settings = '0;
      dot_now = '0;
      predicted_q.delete();
    end else begin
      if (tick.valid && tick.ready) begin
        predicted_q.push_back(dot_actions(settings, tick.line_kind, tick.sprites_on_line,
                                          dot_now));
        dot_now = (dot_now == DotLast) ? '0 : dot_now + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BG_ENABLE:     settings.bg_enable = cfg_data;
          CFG_BG_CLIP:       settings.bg_clip = cfg_data;
          CFG_SPRITE_ENABLE: settings.sprite_enable = cfg_data;
          CFG_SPRITE_CLIP:   settings.sprite_clip = cfg_data;
          default: ;
        endcase
      end
      if (action.valid && action.ready) begin
        got = {action.dot_index, action.fetch_kind, action.vert_step_horiz_reload,
               action.vert_reload, action.sprite_fetch_op, action.sprite_slot,
               action.bg_action, action.sprite_eval_op, action.sprite_eval_index,
               action.mask_sprite_pixel, action.clear_status_flags, action.end_of_line};
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("action beat for dot %0d with nothing outstanding",
                                    action.dot_index));
        end else begin
          want = predicted_q.pop_front();
          compare_field("dot_index", got.dot_index, want.dot_index, want.dot_index);
          compare_field("fetch_kind", got.fetch_kind, want.fetch_kind, want.dot_index);
          compare_field("vert_step_horiz_reload", got.vert_step_horiz_reload,
                        want.vert_step_horiz_reload, want.dot_index);
          compare_field("vert_reload", got.vert_reload, want.vert_reload, want.dot_index);
          compare_field("sprite_fetch_op", got.sprite_fetch_op, want.sprite_fetch_op,
                        want.dot_index);
          compare_field("sprite_slot", got.sprite_slot, want.sprite_slot, want.dot_index);
          compare_field("bg_action", got.bg_action, want.bg_action, want.dot_index);
          compare_field("sprite_eval_op", got.sprite_eval_op, want.sprite_eval_op,
                        want.dot_index);
          compare_field("sprite_eval_index", got.sprite_eval_index, want.sprite_eval_index,
                        want.dot_index);
          compare_field("mask_sprite_pixel", got.mask_sprite_pixel, want.mask_sprite_pixel,
                        want.dot_index);
          compare_field("clear_status_flags", got.clear_status_flags,
                        want.clear_status_flags, want.dot_index);
          compare_field("end_of_line", got.end_of_line, want.end_of_line, want.dot_index);
          beats_checked++;
        end
      end
    end
    outstanding <= predicted_q.size();
  end

endmodule

### bench/tb_scanline_dot_action_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scanline_dot_action_sequencer
// Stimulus and verdict for the scanline dot action sequencer. A short directed
// run covers the render-off and all-on settings near the start of a line and
// the sprite count extremes; then random phases, each under its own settings,
// send line-shaped tick runs with occasional stray ticks, with random idling
// on both channels and one long hold on the action side.
// ----------------------------------------------------------------------------
module tb_scanline_dot_action_sequencer;
  import sdas_pkg::*;

  localparam int TickTarget = 1400;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 80;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic       cfg_data;

  sdas_tick_if   tick_ch ();
  sdas_action_if action_ch ();

  int              outstanding;
  int              failures;
  int              checked;
  int              ticks_sent = 0;
  int              phases = 0;
  int              wraps = 0;
  int              cycle_count = 0;
  logic [DotW-1:0] next_dot = '0;
  bit              hold_request = 1'b0;
  bit              calm_send = 1'b0;
  bit              calm_recv = 1'b0;
  logic            cur_kind = 1'b0;
  logic [3:0]      cur_count = '0;

  scanline_dot_action_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .action    (action_ch)
  );

  sdas_action_checker action_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tick        (tick_ch),
    .action      (action_ch),
    .outstanding (outstanding),
    .failures    (failures),
    .checked     (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("scanline_dot_action_sequencer: mismatch");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_tick(input logic kind, input logic [3:0] count);
    int gap;
    gap = draw_gap(calm_send);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.line_kind <= kind;
    tick_ch.sprites_on_line <= count;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
    if (next_dot == DotLast) begin
      next_dot = '0;
      wraps++;
    end else begin
      next_dot++;
    end
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_index_t'(2'(i));
      cfg_data <= s[3-i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int gap;
    action_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        gap = LongHold;
        hold_request = 1'b0;
      end else begin
        gap = draw_gap(calm_recv);
      end
      if (gap > 0) begin
        action_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      action_ch.ready <= 1'b1;
      do @(posedge clk); while (!action_ch.valid);
    end
  end

  initial begin : stimulus
    logic [3:0] counts [6];
    cfg_t       s;
    int         len;
    counts = '{4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd15};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BG_ENABLE;
    cfg_data <= 1'b0;
    tick_ch.valid <= 1'b0;
    tick_ch.line_kind <= 1'b0;
    tick_ch.sprites_on_line <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tick(1'b1, 4'd0);
    send_tick(1'b0, 4'd15);
    send_tick(1'b0, 4'd8);
    send_tick(1'b1, 4'd9);
    drain();
    apply_settings(4'b1111);
    for (int i = 0; i < 20; i++) begin
      send_tick(i % 3 == 2, counts[i % 6]);
    end

    while (ticks_sent < TickTarget) begin
      drain();
      case (phases)
        0: s = '0;
        1: s = '1;
        default: s = cfg_t'(4'($urandom_range(0, 15)));
      endcase
      apply_settings(s);
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      if (phases == 2) begin
        hold_request = 1'b1;
      end
      len = $urandom_range(150, 420);
      if (len > TickTarget - ticks_sent) begin
        len = TickTarget - ticks_sent;
      end
      for (int i = 0; i < len; i++) begin
        if (next_dot == '0 || i == 0 || $urandom_range(0, 199) == 0) begin
          cur_kind = ($urandom_range(0, 3) == 0);
          cur_count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
        end
        if ($urandom_range(0, 9) == 0) begin
          send_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end else begin
          send_tick(cur_kind, cur_count);
        end
      end
      phases++;
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d dot ticks under %0d random settings phases, %0d line wraps.",
             ticks_sent, phases, wraps);
    $display("Checked %0d action beats field by field, %0d mismatches.", checked, failures);
    if (failures == 0 && outstanding == 0) begin
      $display("scanline_dot_action_sequencer: match");
    end else begin
      $display("scanline_dot_action_sequencer: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
sv/sdas_pkg.sv
sv/sdas_if.sv
sv/sdas_cfg_regs.sv
sv/sdas_dot_decode.sv
sv/scanline_dot_action_sequencer.sv
bench/sdas_action_checker.sv
bench/tb_scanline_dot_action_sequencer.sv
